/* src/lem_pkg.sv */
// ----------------------------------------------------------------------------
// lem_pkg
// Shared types and constants of the local extremum marker.
// ----------------------------------------------------------------------------
`default_nettype none

package lem_pkg;

   localparam int PIX_W        = 8;
   localparam int OUT_W        = 9;
   localparam int WIDTH_REG_W  = 6;
   localparam int HEIGHT_REG_W = 11;
   localparam int ROW_W        = 10;
   localparam int CSR_DATA_W   = 11;
   localparam int CSR_INDEX_W  = 1;
   localparam int SLOTS        = 4;
   localparam int SLOT_W       = 2;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QPTR_W       = 2;
   localparam int QCNT_W       = 3;
   localparam int WORD_W       = 2 * PIX_W;

   localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT = HEIGHT_REG_W'(1024);
   localparam logic [OUT_W-1:0]        MARK_VALUE   = 9'h1FF;
   localparam logic [SLOT_W-1:0]       SLOT_CORNER  = 2'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef logic [PIX_W-1:0]        pixel_type;
   typedef logic signed [OUT_W-1:0] rsp_pixel_type;
   typedef logic [8:0][PIX_W-1:0]   window_type;

   typedef struct packed {
      logic row_ge1;
      logic row_ge2;
      logic col_ge1;
      logic col_ge2;
      logic last_col;
      logic last_row;
   } pos_flags_type;

   typedef struct packed {
      logic [SLOTS-1:0]            mask;
      logic [SLOTS-1:0][OUT_W-1:0] pix;
   } rsp_group_type;

endpackage

`default_nettype wire

/* src/lem_row_store.sv */
// ----------------------------------------------------------------------------
// lem_row_store
// Line store holding the two previous rows, one word per column.
// ----------------------------------------------------------------------------
`default_nettype none

module lem_row_store #(
   parameter int DEPTH = 32,
   parameter int AW    = 5
) (
   input  wire logic                      clock,
   input  wire logic                      rd_en,
   input  wire logic [AW-1:0]             rd_addr,
   output logic [lem_pkg::WORD_W-1:0]     rd_data,
   input  wire logic                      wr_en,
   input  wire logic [AW-1:0]             wr_addr,
   input  wire logic [lem_pkg::WORD_W-1:0] wr_data
);
   import lem_pkg::*;

   logic [WORD_W-1:0] row_mem [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/lem_rsp_queue.sv */
// ----------------------------------------------------------------------------
// lem_rsp_queue
// Queue of result groups, drained one result per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module lem_rsp_queue (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         push,
   input  wire lem_pkg::rsp_group_type       push_group,
   output logic [lem_pkg::QCNT_W-1:0]        count,
   output logic                              rsp_valid,
   input  wire logic                         rsp_stall,
   output lem_pkg::rsp_pixel_type            rsp_pixel_out,
   output logic                              rsp_frame_done
);
   import lem_pkg::*;

   rsp_group_type     groups_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic [SLOTS-1:0]  sent_ff, sent_in;

   rsp_group_type    head;
   logic [SLOTS-1:0] remaining;
   logic [SLOTS-1:0] low_bit;
   logic [SLOT_W-1:0] slot;
   logic             take;
   logic             pop;

   assign head      = groups_ff[rd_ptr_ff];
   assign remaining = head.mask & ~sent_ff;

   always_comb begin
      slot    = '0;
      low_bit = '0;
      for (int k = SLOTS - 1; k >= 0; k--) begin
         if (remaining[k]) begin
            slot    = SLOT_W'(k);
            low_bit = SLOTS'(1) << k;
         end
      end
   end

   assign rsp_valid      = (count_ff != '0);
   assign rsp_pixel_out  = rsp_pixel_type'(head.pix[slot]);
   assign rsp_frame_done = (slot == SLOT_CORNER);
   assign count          = count_ff;

   assign take = rsp_valid && !rsp_stall;
   assign pop  = take && ((remaining & ~low_bit) == '0);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
      sent_in = sent_ff;
      if (pop) begin
         sent_in = '0;
      end else if (take) begin
         sent_in = sent_ff | low_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         groups_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         sent_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         sent_ff   <= sent_in;
      end
   end

endmodule

`default_nettype wire

/* src/local_extremum_marker.sv */
// ----------------------------------------------------------------------------
// local_extremum_marker
// Streaming 3x3 strict local extremum marker over a row-major pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter one per clock while req_stall is low. A pixel leaves
// unchanged, or as -1 when it is strictly above or strictly below every
// in-frame neighbour of its 3x3 window; it leaves once its last neighbour
// has arrived, one row plus one pixel behind the input, and the last row is
// sent while it is received, with rsp_frame_done on the frame's final pixel.
// From acceptance to the result queue, each pixel passes through a read of
// the line store, the window update with write-back (forwarded when the
// same column repeats, as at width one), and the comparisons for four window
// positions. req_stall rises when queued groups and pixels in flight fill the
// four-group result queue, which sends one result per clock while rsp_stall
// is low; the last column and last row yield more than one result per pixel,
// so there the input is held back. Writing either register restarts the
// frame; line store contents are kept and need no clearing after reset.
`default_nettype none

module local_extremum_marker #(
   parameter int MAX_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire lem_pkg::pixel_type             req_pixel_in,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output lem_pkg::rsp_pixel_type              rsp_pixel_out,
   output logic                                rsp_frame_done,
   input  wire logic                           csr_write,
   input  wire lem_pkg::csr_index_type         csr_index,
   input  wire logic [lem_pkg::CSR_DATA_W-1:0] csr_data
);
   import lem_pkg::*;

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [WIDTH_REG_W:0] MAX_WIDTH_V = (WIDTH_REG_W + 1)'(MAX_WIDTH);
   localparam logic [COL_W-1:0]     MAX_COL     = COL_W'(MAX_WIDTH - 1);

   function automatic logic [OUT_W-1:0] judge(
      input window_type win,
      input int         ci,
      input int         cj,
      input logic [2:0] row_in,
      input logic [2:0] col_in
   );
      logic [PIX_W-1:0] v;
      logic [PIX_W-1:0] n;
      logic             above;
      logic             below;
      v     = win[ci * 3 + cj];
      above = 1'b1;
      below = 1'b1;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            n = win[i * 3 + j];
            if (!(i == ci && j == cj) && (i - ci) <= 1 && (ci - i) <= 1 &&
                (j - cj) <= 1 && (cj - j) <= 1 && row_in[i] && col_in[j]) begin
               if (!(v > n)) begin
                  above = 1'b0;
               end
               if (!(v < n)) begin
                  below = 1'b0;
               end
            end
         end
      end
      return (above || below) ? MARK_VALUE : {1'b0, v};
   endfunction

   // configuration
   logic [COL_W-1:0] width_last_ff, width_last_in;
   logic [ROW_W-1:0] height_last_ff, height_last_in;
   logic [WIDTH_REG_W-1:0]  wr_width;
   logic [WIDTH_REG_W-1:0]  wr_width_m1;
   logic [HEIGHT_REG_W-1:0] wr_height;
   logic [HEIGHT_REG_W-1:0] wr_height_m1;
   logic                    restart;

   // position counters
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] cur_col;
   logic [ROW_W-1:0] cur_row;
   pos_flags_type    cur_flags;
   logic             accept;

   // read stage
   logic             s1_valid_ff;
   logic [COL_W-1:0] s1_col_ff;
   pixel_type        s1_pix_ff;
   pos_flags_type    s1_flags_ff;
   logic             s1_hit_ff;
   logic [WORD_W-1:0] s1_fwd_ff;
   logic [WORD_W-1:0] mem_rd;
   logic [WORD_W-1:0] rd_eff;
   logic [WORD_W-1:0] wr_word;
   logic              hit_in;

   // judge stage
   logic          s2_valid_ff;
   pos_flags_type s2_flags_ff;
   window_type    window_ff, window_in;
   logic [2:0]    row_ok;
   logic [2:0]    col_ok;
   rsp_group_type group;

   // result queue
   logic [QCNT_W-1:0] q_count;
   logic [QCNT_W:0]   busy;

   assign wr_width     = csr_data[WIDTH_REG_W-1:0];
   assign wr_width_m1  = wr_width - 1'b1;
   assign wr_height    = csr_data[HEIGHT_REG_W-1:0];
   assign wr_height_m1 = wr_height - 1'b1;

   always_comb begin
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      restart        = 1'b0;
      if (csr_write) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               restart = 1'b1;
               if (wr_width == '0) begin
                  width_last_in = '0;
               end else if ({1'b0, wr_width} > MAX_WIDTH_V) begin
                  width_last_in = MAX_COL;
               end else begin
                  width_last_in = wr_width_m1[COL_W-1:0];
               end
            end
            CSR_FRAME_HEIGHT: begin
               restart = 1'b1;
               if (wr_height == '0) begin
                  height_last_in = '0;
               end else if (wr_height > HEIGHT_LIMIT) begin
                  height_last_in = '1;
               end else begin
                  height_last_in = wr_height_m1[ROW_W-1:0];
               end
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   assign busy      = (QCNT_W + 1)'(q_count) + (QCNT_W + 1)'(s1_valid_ff)
                    + (QCNT_W + 1)'(s2_valid_ff);
   assign req_stall = (busy >= (QCNT_W + 1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign cur_col = (col_ff > width_last_ff) ? '0 : col_ff;
   assign cur_row = (row_ff > height_last_ff) ? '0 : row_ff;

   always_comb begin
      cur_flags.row_ge1  = (cur_row != '0);
      cur_flags.row_ge2  = (cur_row > ROW_W'(1));
      cur_flags.col_ge1  = (cur_col != '0);
      cur_flags.col_ge2  = (cur_col > COL_W'(1));
      cur_flags.last_col = (cur_col == width_last_ff);
      cur_flags.last_row = (cur_row == height_last_ff);
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (restart) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (cur_flags.last_col) begin
            col_in = '0;
            row_in = cur_flags.last_row ? '0 : cur_row + 1'b1;
         end else begin
            col_in = cur_col + 1'b1;
         end
      end
   end

   // same column back to back: the store read misses the write in flight
   assign rd_eff  = s1_hit_ff ? s1_fwd_ff : mem_rd;
   assign wr_word = {rd_eff[PIX_W-1:0], s1_pix_ff};
   assign hit_in  = s1_valid_ff && (s1_col_ff == cur_col);

   lem_row_store #(
      .DEPTH (MAX_WIDTH),
      .AW    (COL_W)
   ) u_row_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (mem_rd),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word)
   );

   always_comb begin
      window_in = window_ff;
      if (s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            window_in[i * 3 + 0] = window_ff[i * 3 + 1];
            window_in[i * 3 + 1] = window_ff[i * 3 + 2];
         end
         window_in[2] = rd_eff[WORD_W-1:PIX_W];
         window_in[5] = rd_eff[PIX_W-1:0];
         window_in[8] = s1_pix_ff;
      end
   end

   assign row_ok = {1'b1, s2_flags_ff.row_ge1, s2_flags_ff.row_ge2};
   assign col_ok = {1'b1, s2_flags_ff.col_ge1, s2_flags_ff.col_ge2};

   always_comb begin
      group.mask[0] = s2_flags_ff.row_ge1 && s2_flags_ff.col_ge1;
      group.mask[1] = s2_flags_ff.row_ge1 && s2_flags_ff.last_col;
      group.mask[2] = s2_flags_ff.last_row && s2_flags_ff.col_ge1;
      group.mask[3] = s2_flags_ff.last_row && s2_flags_ff.last_col;
      group.pix[0]  = judge(window_ff, 1, 1, row_ok, col_ok);
      group.pix[1]  = judge(window_ff, 1, 2, row_ok, col_ok);
      group.pix[2]  = judge(window_ff, 2, 1, row_ok, col_ok);
      group.pix[3]  = judge(window_ff, 2, 2, row_ok, col_ok);
   end

   lem_rsp_queue u_rsp_queue (
      .clock          (clock),
      .reset          (reset),
      .push           (s2_valid_ff && (group.mask != '0)),
      .push_group     (group),
      .count          (q_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_frame_done (rsp_frame_done)
   );

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff   <= cur_col;
         s1_pix_ff   <= req_pixel_in;
         s1_flags_ff <= cur_flags;
         s1_hit_ff   <= hit_in;
         s1_fwd_ff   <= wr_word;
      end
      if (s1_valid_ff) begin
         s2_flags_ff <= s1_flags_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_last_ff  <= COL_W'(2);
         height_last_ff <= ROW_W'(3);
         col_ff         <= '0;
         row_ff         <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         window_ff      <= '0;
      end else begin
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         s1_valid_ff    <= accept;
         s2_valid_ff    <= s1_valid_ff;
         window_ff      <= window_in;
      end
   end

endmodule

`default_nettype wire
